// File: rtl/core/partial_shuffle_sampler_unit_macros.svh
// Assertion macros shared by the sampler RTL.
// Each macro expects signals named clk and rst_n in the calling module.
`ifndef PARTIAL_SHUFFLE_SAMPLER_UNIT_MACROS_SVH
`define PARTIAL_SHUFFLE_SAMPLER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Condition that must hold at every clock edge outside reset.
`define PSS_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("sampler check failed");

// Consequence that must hold in the same cycle as its cause.
`define PSS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sampler check failed");

// Consequence that must hold in the cycle after its cause.
`define PSS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sampler check failed");

`else

`define PSS_ASSERT_ALWAYS(lbl, expr)
`define PSS_ASSERT_IMPL(lbl, ante, cons)
`define PSS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: rtl/core/psshuf_pkg.sv
package psshuf_pkg;

  // Width of the configuration registers and of table positions.
  localparam int CFG_W = 11;

  // Width of the configuration register index.
  localparam int CFG_IDX_W = 2;

  // Width of the random word port.
  localparam int RND_PORT_W = 32;

  // Width of the drawn value port.
  localparam int OUT_W = 10;

  // Width of the run epoch stored with each table entry.
  localparam int EPOCH_W = 8;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DRAW_COUNT = 2'd1;

  // Reset values of the registers.
  localparam logic [CFG_W-1:0] RANGE_SIZE_RST = 11'd1024;
  localparam logic [CFG_W-1:0] DRAW_COUNT_RST = 11'd1024;

  // Epoch values: zero marks a swept entry, the last value forces a new sweep.
  localparam logic [EPOCH_W-1:0] EPOCH_CLEAR = '0;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

endpackage

// File: rtl/core/partial_shuffle_sampler_unit.sv
// Partial shuffle sampler: each input item carries a random word and yields
// one result item holding the next distinct value of the current run, drawn
// from 0 to range_size-1 by a partial Fisher-Yates shuffle.
// Channels: in_* and out_* use valid/stall, an item moves when valid is high
// and stall is low. The cfg_* port writes range_size (index 0) or
// draw_count (index 1) when cfg_valid and cfg_ready are both high; any
// such write restarts the run. Writes to other indexes are ignored.
// Timing: items are taken only in the idle state. Each one passes through
// the bit-serial remainder unit, one random bit per cycle, then the table
// read of entry j and the two write-backs on the table; only then can the
// next item be accepted. The result is registered at the last write-back.
// Reset: registers take their reset values, then a clearing pass sweeps
// all RANGE_MAX table entries; the same pass runs again after every 255th
// run restart outside a pass. No input item is accepted during a pass or
// while a register write is offered.
// A stalled result is held in the output register; barring a setup error,
// the next item is still accepted, but its result waits until that register is free.
// A setup error (draw_count above range_size, range_size above RANGE_MAX,
// or a zero register) gives an error result straight from the idle state.
`include "partial_shuffle_sampler_unit_macros.svh"

module partial_shuffle_sampler_unit #(
  parameter int RANGE_MAX   = 1024,
  parameter int RANDOM_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [psshuf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [psshuf_pkg::CFG_W-1:0]         cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [psshuf_pkg::RND_PORT_W-1:0]    in_random_word,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [psshuf_pkg::OUT_W-1:0]         out_drawn_value,
  output logic                                 out_last_draw,
  output logic                                 out_setup_error
);

  localparam int IDX_W = (RANGE_MAX > 1) ? $clog2(RANGE_MAX) : 1;
  localparam int RND_W = (RANDOM_BITS < psshuf_pkg::RND_PORT_W) ?
                         RANDOM_BITS : psshuf_pkg::RND_PORT_W;
  localparam int CNT_W = $clog2(RND_W);
  localparam int CW    = psshuf_pkg::CFG_W;
  localparam int EW    = psshuf_pkg::EPOCH_W;
  localparam int ENT_W = EW + IDX_W;
  localparam logic [IDX_W-1:0] SWEEP_LAST = IDX_W'(RANGE_MAX - 1);

  typedef enum logic [5:0] {
    ST_SWEEP = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_DIV   = 6'b000100,
    ST_RDJ   = 6'b001000,
    ST_GETB  = 6'b010000,
    ST_WRI   = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     range_size_r, range_size_nxt;
  logic [CW-1:0]     draw_count_r, draw_count_nxt;
  logic [CW-1:0]     draw_idx_r, draw_idx_nxt;
  logic [EW-1:0]     epoch_r, epoch_nxt;
  logic [IDX_W-1:0]  sweep_cnt_r, sweep_cnt_nxt;
  logic [RND_W-1:0]  rnd_r, rnd_nxt;
  logic [CW-1:0]     rem_r, rem_nxt;
  logic [CW-1:0]     span_r, span_nxt;
  logic [CNT_W-1:0]  bit_cnt_r, bit_cnt_nxt;
  logic [CW-1:0]     a_r, a_nxt;
  logic [CW-1:0]     b_r, b_nxt;
  logic [CW-1:0]     j_r, j_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [psshuf_pkg::OUT_W-1:0]  out_value_r, out_value_nxt;
  logic                          out_last_r, out_last_nxt;
  logic                          out_err_r, out_err_nxt;

  logic [ENT_W-1:0]  table_mem [RANGE_MAX];
  logic [ENT_W-1:0]  rd_data_r;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [ENT_W-1:0]  mem_wdata;
  logic [IDX_W-1:0]  mem_raddr;

  logic              setup_err;
  logic              out_free;
  logic              in_acc;
  logic              cfg_acc;
  logic              run_start;
  logic [CW:0]       trial;
  logic              trial_ge;
  logic [CW-1:0]     rem_step;
  logic              last_draw;

  // An entry from an earlier run reads as its own position.
  function automatic logic [CW-1:0] entry_val(input logic [ENT_W-1:0] e,
                                              input logic [EW-1:0]    ep,
                                              input logic [CW-1:0]    pos);
    logic [CW-1:0] v;
    if (e[ENT_W-1 -: EW] == ep) begin
      v = CW'(e[IDX_W-1:0]);
    end else begin
      v = pos;
    end
    return v;
  endfunction

  // Configurations that admit no valid draw.
  assign setup_err = (range_size_r == '0) || (draw_count_r == '0) ||
                     (32'(range_size_r) > 32'(RANGE_MAX)) ||
                     (draw_count_r > range_size_r);

  // Handshakes; a register write takes precedence over an input item.
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || (setup_err && !out_free) || cfg_valid;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = (state_r == ST_IDLE) || (state_r == ST_SWEEP);
  assign cfg_acc   = cfg_valid && cfg_ready;

  // One restoring step of the remainder, most significant random bit first.
  assign trial    = {rem_r, rnd_r[RND_W-1]};
  assign trial_ge = trial >= {1'b0, span_r};
  assign rem_step = trial_ge ? CW'(trial - {1'b0, span_r}) : trial[CW-1:0];

  assign last_draw = ({1'b0, draw_idx_r} + (CW+1)'(1)) >= {1'b0, draw_count_r};

  // Sequencer and register updates.
  always_comb begin
    state_nxt      = state_r;
    range_size_nxt = range_size_r;
    draw_count_nxt = draw_count_r;
    draw_idx_nxt   = draw_idx_r;
    epoch_nxt      = epoch_r;
    sweep_cnt_nxt  = sweep_cnt_r;
    rnd_nxt        = rnd_r;
    rem_nxt        = rem_r;
    span_nxt       = span_r;
    bit_cnt_nxt    = bit_cnt_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    j_nxt          = j_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    out_err_nxt    = out_err_r;
    out_valid_nxt  = out_valid_r && out_stall;
    mem_we         = 1'b0;
    mem_waddr      = IDX_W'(j_r);
    mem_wdata      = {epoch_r, IDX_W'(a_r)};
    mem_raddr      = IDX_W'(draw_idx_r);
    run_start      = 1'b0;

    unique case (state_r)
      ST_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_cnt_r;
        mem_wdata = '0;
        if (sweep_cnt_r == SWEEP_LAST) begin
          state_nxt = ST_IDLE;
        end else begin
          sweep_cnt_nxt = sweep_cnt_r + IDX_W'(1);
        end
      end
      ST_IDLE: begin
        // The read of entry i is issued here while the item is taken.
        if (in_acc) begin
          if (setup_err) begin
            out_valid_nxt = 1'b1;
            out_value_nxt = '0;
            out_last_nxt  = 1'b0;
            out_err_nxt   = 1'b1;
          end else begin
            rnd_nxt     = in_random_word[RND_W-1:0];
            rem_nxt     = '0;
            span_nxt    = range_size_r - draw_idx_r;
            bit_cnt_nxt = CNT_W'(RND_W - 1);
            state_nxt   = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (bit_cnt_r == CNT_W'(RND_W - 1)) begin
          a_nxt = entry_val(rd_data_r, epoch_r, draw_idx_r);
        end
        rem_nxt     = rem_step;
        rnd_nxt     = rnd_r << 1;
        bit_cnt_nxt = bit_cnt_r - CNT_W'(1);
        if (bit_cnt_r == '0) begin
          j_nxt     = draw_idx_r + rem_step;
          state_nxt = ST_RDJ;
        end
      end
      ST_RDJ: begin
        mem_raddr = IDX_W'(j_r);
        state_nxt = ST_GETB;
      end
      ST_GETB: begin
        // Entry j takes the old entry i; both reads are already done.
        b_nxt     = entry_val(rd_data_r, epoch_r, j_r);
        mem_we    = 1'b1;
        mem_waddr = IDX_W'(j_r);
        mem_wdata = {epoch_r, IDX_W'(a_r)};
        state_nxt = ST_WRI;
      end
      ST_WRI: begin
        // Entry i takes the old entry j; repeated while the output is busy.
        mem_we    = 1'b1;
        mem_waddr = IDX_W'(draw_idx_r);
        mem_wdata = {epoch_r, IDX_W'(b_r)};
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = psshuf_pkg::OUT_W'(b_r);
          out_last_nxt  = last_draw;
          out_err_nxt   = 1'b0;
          state_nxt     = ST_IDLE;
          if (last_draw) begin
            run_start = 1'b1;
          end else begin
            draw_idx_nxt = draw_idx_r + CW'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_SWEEP;
      end
    endcase

    // Writes to range_size or draw_count restart the run.
    if (cfg_acc) begin
      case (cfg_index)
        psshuf_pkg::REG_RANGE_SIZE: begin
          range_size_nxt = cfg_data;
          run_start      = 1'b1;
        end
        psshuf_pkg::REG_DRAW_COUNT: begin
          draw_count_nxt = cfg_data;
          run_start      = 1'b1;
        end
        default: begin
        end
      endcase
    end

    // A new run moves to a fresh epoch, sweeping the table when they run out.
    if (run_start) begin
      draw_idx_nxt = '0;
      if (state_nxt != ST_SWEEP) begin
        if (epoch_r == psshuf_pkg::EPOCH_LAST) begin
          epoch_nxt     = psshuf_pkg::EPOCH_FIRST;
          sweep_cnt_nxt = '0;
          state_nxt     = ST_SWEEP;
        end else begin
          epoch_nxt = epoch_r + EW'(1);
        end
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_SWEEP;
      range_size_r <= psshuf_pkg::RANGE_SIZE_RST;
      draw_count_r <= psshuf_pkg::DRAW_COUNT_RST;
      draw_idx_r   <= '0;
      epoch_r      <= psshuf_pkg::EPOCH_FIRST;
      sweep_cnt_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      range_size_r <= range_size_nxt;
      draw_count_r <= draw_count_nxt;
      draw_idx_r   <= draw_idx_nxt;
      epoch_r      <= epoch_nxt;
      sweep_cnt_r  <= sweep_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    rnd_r       <= rnd_nxt;
    rem_r       <= rem_nxt;
    span_r      <= span_nxt;
    bit_cnt_r   <= bit_cnt_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    j_r         <= j_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
    out_err_r   <= out_err_nxt;
  end

  // Permutation table with epoch marks, one write and one registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= table_mem[mem_raddr];
  end

  assign out_valid       = out_valid_r;
  assign out_drawn_value = out_value_r;
  assign out_last_draw   = out_last_r;
  assign out_setup_error = out_err_r;

  // Checks on the sequencer and the remainder unit.
  `PSS_ASSERT_IMPL(a_rem_below_span, state_r == ST_DIV, rem_r < span_r)
  `PSS_ASSERT_IMPL(a_j_in_range, state_r == ST_RDJ, (j_r < range_size_r) && (j_r >= draw_idx_r))
  `PSS_ASSERT_IMPL(a_idx_in_run, !setup_err, draw_idx_r < draw_count_r)
  `PSS_ASSERT_ALWAYS(a_epoch_live, epoch_r != psshuf_pkg::EPOCH_CLEAR)
  `PSS_ASSERT_IMPL(a_sweep_blocks, state_r == ST_SWEEP, in_stall)

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int RANGE_MAX     = 1024;
  localparam int RANDOM_BITS   = 32;
  localparam int STALL_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 64;
  localparam int PHASE_ITEMS   = 640;

  // Register indexes that lie beyond the register list and must be ignored.
  localparam logic [psshuf_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [psshuf_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  // Which registers one reprogramming step writes.
  typedef enum int {
    WRITE_RANGE_ONLY,
    WRITE_DRAW_ONLY,
    WRITE_BOTH
  } cfg_write_mode_t;

  typedef struct packed {
    logic [psshuf_pkg::OUT_W-1:0] drawn_value;
    logic                         last_draw;
    logic                         setup_error;
  } draw_result_t;

  logic                              clk;
  logic                              rst_n          = 1'b0;
  logic                              cfg_valid      = 1'b0;
  logic                              cfg_ready;
  logic [psshuf_pkg::CFG_IDX_W-1:0]  cfg_index      = psshuf_pkg::REG_RANGE_SIZE;
  logic [psshuf_pkg::CFG_W-1:0]      cfg_data       = '0;
  logic                              in_valid       = 1'b0;
  logic                              in_stall;
  logic [psshuf_pkg::RND_PORT_W-1:0] in_random_word = '0;
  logic                              out_valid;
  logic                              out_stall      = 1'b0;
  logic [psshuf_pkg::OUT_W-1:0]      out_drawn_value;
  logic                              out_last_draw;
  logic                              out_setup_error;

  int send_idle_pct = 9;
  int recv_idle_pct = 63;
  int mismatch_count = 0;
  int quiet_cycles = 0;
  bit in_active = 1'b0;

  // Shadow copy of the shuffle state used to predict every draw.
  logic [psshuf_pkg::OUT_W-1:0] shuffle_table [RANGE_MAX];
  bit                           entry_written [RANGE_MAX];
  int unsigned                  range_size_cfg;
  int unsigned                  draw_count_cfg;
  int unsigned                  draw_pos;
  draw_result_t                 expected_draws [$];

  partial_shuffle_sampler_unit #(
    .RANGE_MAX   (RANGE_MAX),
    .RANDOM_BITS (RANDOM_BITS)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_random_word  (in_random_word),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_drawn_value (out_drawn_value),
    .out_last_draw   (out_last_draw),
    .out_setup_error (out_setup_error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A new run starts with every table entry reading as its own index.
  function automatic void clear_run();
    foreach (entry_written[k]) entry_written[k] = 1'b0;
    draw_pos = 0;
  endfunction

  function automatic logic [psshuf_pkg::OUT_W-1:0] table_entry(int unsigned pos);
    return entry_written[pos] ? shuffle_table[pos] : psshuf_pkg::OUT_W'(pos);
  endfunction

  // Registers outside the list leave both the settings and the run alone.
  function automatic void note_register_write(logic [psshuf_pkg::CFG_IDX_W-1:0] idx,
                                              logic [psshuf_pkg::CFG_W-1:0] data);
    if (idx == psshuf_pkg::REG_RANGE_SIZE) begin
      range_size_cfg = 32'(data);
    end else if (idx == psshuf_pkg::REG_DRAW_COUNT) begin
      draw_count_cfg = 32'(data);
    end else begin
      return;
    end
    clear_run();
  endfunction

  // One swap step of the partial shuffle, giving the expected result item.
  function automatic void predict_draw(logic [psshuf_pkg::RND_PORT_W-1:0] word);
    draw_result_t res;
    int unsigned  pos;
    int unsigned  swap_pos;
    logic [psshuf_pkg::OUT_W-1:0] at_pos;
    logic [psshuf_pkg::OUT_W-1:0] at_swap;
    res = '0;
    if (range_size_cfg == 0 || draw_count_cfg == 0 || range_size_cfg > RANGE_MAX ||
        draw_count_cfg > range_size_cfg) begin
      res.setup_error = 1'b1;
    end else begin
      if (draw_pos >= draw_count_cfg) clear_run();
      pos = draw_pos;
      swap_pos = pos + word % (range_size_cfg - pos);
      at_pos = table_entry(pos);
      at_swap = table_entry(swap_pos);
      shuffle_table[swap_pos] = at_pos;
      entry_written[swap_pos] = 1'b1;
      shuffle_table[pos] = at_swap;
      entry_written[pos] = 1'b1;
      res.drawn_value = at_swap;
      res.last_draw = (pos + 1 >= draw_count_cfg);
      if (res.last_draw) begin
        clear_run();
      end else begin
        draw_pos = pos + 1;
      end
    end
    expected_draws.push_back(res);
  endfunction

  // Mostly uniform words, with the extremes and small values mixed in.
  function automatic logic [psshuf_pkg::RND_PORT_W-1:0] pick_word();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      2: return psshuf_pkg::RND_PORT_W'($urandom_range(0, 2047));
      default: return $urandom;
    endcase
  endfunction

  // Send one item, idling beforehand at the current rate.
  task automatic send_draw(input logic [psshuf_pkg::RND_PORT_W-1:0] word);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      if (in_active) begin
        in_valid <= 1'b0;
        in_active = 1'b0;
      end
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_active = 1'b1;
    in_random_word <= word;
    do @(posedge clk); while (in_stall);
    predict_draw(word);
  endtask

  // Drop the input valid and wait until every expected item has come back.
  task automatic wait_drained();
    if (in_active) begin
      in_valid <= 1'b0;
      in_active = 1'b0;
    end
    while (expected_draws.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [psshuf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [psshuf_pkg::CFG_W-1:0] data,
                           input bit release_port);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    note_register_write(idx, data);
    if (release_port) cfg_valid <= 1'b0;
  endtask

  // Registers are only written once the block has gone idle.
  task automatic configure(input logic [psshuf_pkg::CFG_W-1:0] range_v,
                           input logic [psshuf_pkg::CFG_W-1:0] draw_v,
                           input cfg_write_mode_t mode);
    wait_drained();
    case (mode)
      WRITE_RANGE_ONLY: cfg_write(psshuf_pkg::REG_RANGE_SIZE, range_v, 1'b1);
      WRITE_DRAW_ONLY:  cfg_write(psshuf_pkg::REG_DRAW_COUNT, draw_v, 1'b1);
      default: begin
        cfg_write(psshuf_pkg::REG_RANGE_SIZE, range_v, 1'b0);
        cfg_write(psshuf_pkg::REG_DRAW_COUNT, draw_v, 1'b1);
      end
    endcase
  endtask

  // Reset settings: the full range with the full run length.
  task automatic test_reset_defaults();
    send_draw('0);
    send_draw('1);
    send_draw(32'h8000_0000);
  endtask

  // A single value to draw from: every draw is 0 and ends its run.
  task automatic test_smallest_range();
    configure(11'd1, 11'd1, WRITE_BOTH);
    send_draw('1);
    send_draw(32'h1234_5678);
  endtask

  // A whole permutation of a small range, ending on the last draw.
  task automatic test_full_permutation();
    configure(11'd4, 11'd4, WRITE_BOTH);
    send_draw('0);
    send_draw('1);
    send_draw(32'd1);
    send_draw(32'd2);
  endtask

  // The largest range with one draw per run.
  task automatic test_largest_range();
    configure(11'd1024, 11'd1, WRITE_BOTH);
    send_draw('1);
    send_draw(32'd1023);
  endtask

  // Every way the settings can admit no valid draw.
  task automatic test_setup_errors();
    configure(11'd3, 11'd4, WRITE_BOTH);
    send_draw($urandom);
    configure(11'd0, 11'd1, WRITE_BOTH);
    send_draw($urandom);
    configure(11'd5, 11'd0, WRITE_BOTH);
    send_draw($urandom);
    configure(11'd2047, 11'd1, WRITE_BOTH);
    send_draw($urandom);
    configure(11'd2047, 11'd2047, WRITE_DRAW_ONLY);
    send_draw($urandom);
  endtask

  // Writes to indexes beyond the list must not restart the run in progress.
  task automatic test_ignored_index();
    configure(11'd6, 11'd6, WRITE_BOTH);
    send_draw(pick_word());
    send_draw(pick_word());
    wait_drained();
    cfg_write(REG_SPARE_2, 11'd2047, 1'b0);
    cfg_write(REG_SPARE_3, 11'd0, 1'b1);
    repeat (4) send_draw(pick_word());
  endtask

  // Rewriting a register with its current value still restarts the run.
  task automatic test_restart_on_write();
    configure(11'd3, 11'd3, WRITE_BOTH);
    send_draw(pick_word());
    configure(11'd3, 11'd3, WRITE_DRAW_ONLY);
    repeat (3) send_draw(pick_word());
  endtask

  // Random segments, each under freshly chosen settings.
  task automatic run_random_phase(input int send_pct, input int recv_pct, input int items);
    int sent;
    int len;
    logic [psshuf_pkg::CFG_W-1:0] range_v;
    logic [psshuf_pkg::CFG_W-1:0] draw_v;
    cfg_write_mode_t mode;
    sent = 0;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    while (sent < items) begin
      case ($urandom_range(0, 9))
        0: begin
          range_v = 11'd1024;
          draw_v = psshuf_pkg::CFG_W'($urandom_range(1, 48));
        end
        1: begin
          range_v = 11'd1;
          draw_v = 11'd1;
        end
        2: begin
          case ($urandom_range(0, 3))
            0: begin
              range_v = psshuf_pkg::CFG_W'($urandom_range(1, 63));
              draw_v = range_v + psshuf_pkg::CFG_W'($urandom_range(1, 64));
            end
            1: begin
              range_v = '0;
              draw_v = psshuf_pkg::CFG_W'($urandom_range(0, 2047));
            end
            2: begin
              range_v = psshuf_pkg::CFG_W'($urandom_range(1, 1024));
              draw_v = '0;
            end
            default: begin
              range_v = psshuf_pkg::CFG_W'($urandom_range(1025, 2047));
              draw_v = psshuf_pkg::CFG_W'($urandom_range(1, 1024));
            end
          endcase
        end
        3: begin
          range_v = psshuf_pkg::CFG_W'($urandom_range(2, 16));
          draw_v = range_v;
        end
        default: begin
          range_v = psshuf_pkg::CFG_W'($urandom_range(1, 64));
          draw_v = psshuf_pkg::CFG_W'($urandom_range(1, range_v));
        end
      endcase
      case ($urandom_range(0, 5))
        0: mode = WRITE_RANGE_ONLY;
        1: mode = WRITE_DRAW_ONLY;
        default: mode = WRITE_BOTH;
      endcase
      configure(range_v, draw_v, mode);
      if (range_size_cfg == 0 || draw_count_cfg == 0 || range_size_cfg > RANGE_MAX ||
          draw_count_cfg > range_size_cfg) begin
        len = $urandom_range(1, 4);
      end else begin
        len = $urandom_range(1, 2 * draw_count_cfg + 1);
        if (len > 96) len = 96;
      end
      repeat (len) send_draw(pick_word());
      sent += len;
    end
  endtask

  // The receiver stalls at random at the current rate.
  always @(posedge clk) begin
    out_stall <= rst_n ? ($urandom_range(0, 99) < recv_idle_pct) : 1'b0;
  end

  // Compare each accepted result item with the oldest expectation.
  always @(posedge clk) begin
    draw_result_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_draws.size() == 0) begin
        $error("unexpected result item: drawn_value %0d last_draw %0b setup_error %0b",
               out_drawn_value, out_last_draw, out_setup_error);
        mismatch_count++;
      end else begin
        exp_res = expected_draws.pop_front();
        if (out_drawn_value !== exp_res.drawn_value) begin
          $error("drawn_value: expected %0d, got %0d", exp_res.drawn_value, out_drawn_value);
          mismatch_count++;
        end
        if (out_last_draw !== exp_res.last_draw) begin
          $error("last_draw: expected %0b, got %0b", exp_res.last_draw, out_last_draw);
          mismatch_count++;
        end
        if (out_setup_error !== exp_res.setup_error) begin
          $error("setup_error: expected %0b, got %0b", exp_res.setup_error, out_setup_error);
          mismatch_count++;
        end
      end
    end
  end

  // Give up when no channel has moved an item for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    range_size_cfg = 32'(psshuf_pkg::RANGE_SIZE_RST);
    draw_count_cfg = 32'(psshuf_pkg::DRAW_COUNT_RST);
    clear_run();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_smallest_range();
    test_full_permutation();
    test_largest_range();
    test_setup_errors();
    test_ignored_index();
    test_restart_on_write();

    run_random_phase(9, 63, PHASE_ITEMS);
    run_random_phase(63, 9, PHASE_ITEMS);
    run_random_phase(0, 0, PHASE_ITEMS);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
